// ----- design/vlpd_pkg.sv -----
package vlpd_pkg;

    // LEB128 byte fields
    localparam logic [7:0] CONT_BIT   = 8'h80;
    localparam logic [7:0] GROUP_MASK = 8'h7F;
    localparam logic [5:0] GROUP_BITS = 6'd7;

    // varint byte limits
    localparam logic [3:0] LIMIT_32 = 4'd5;
    localparam logic [3:0] LIMIT_64 = 4'd10;

    // default queue depths
    localparam int DEF_FRONT_DEPTH = 2;
    localparam int DEF_OUT_DEPTH   = 2;

    // decode_mode codes; the unused code decodes as varint64
    localparam logic [1:0] MODE_VARINT32 = 2'd0;
    localparam logic [1:0] MODE_VARINT64 = 2'd1;
    localparam logic [1:0] MODE_RECORD   = 2'd2;

    typedef enum logic [1:0] {
        KIND_VALUE   = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_ERROR   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_OVERLONG  = 2'd1,
        ERR_TRUNCATED = 2'd2,
        ERR_SHORT     = 2'd3
    } t_err;

    // classified input beat
    typedef struct packed {
        logic [7:0] data_byte;
        logic       present;
        logic       end_flag;
        logic       cont;
    } t_item;

    // one result beat
    typedef struct packed {
        t_kind       kind;
        logic [63:0] value;
        logic [7:0]  pbyte;
        t_err        err;
        logic        last;
        logic [3:0]  used;
    } t_result;

endpackage

// ----- design/vlpd_front.sv -----
module vlpd_front #(
    parameter int FRONT_DEPTH = vlpd_pkg::DEF_FRONT_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  logic [7:0]       i_data_byte,
    input  logic             i_byte_present,
    input  logic             i_input_end,
    output logic             o_item_valid,
    output vlpd_pkg::t_item  o_item,
    input  logic             i_item_take
);

    localparam int PW = (FRONT_DEPTH > 1) ? $clog2(FRONT_DEPTH) : 1;
    localparam int CW = $clog2(FRONT_DEPTH + 1);

    vlpd_pkg::t_item r_mem [FRONT_DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          wr_en, rd_en;
    vlpd_pkg::t_item in_item;

    always_comb begin
        in_item.data_byte = i_data_byte;
        in_item.present   = i_byte_present;
        in_item.end_flag  = i_input_end;
        in_item.cont      = i_byte_present & ((i_data_byte & vlpd_pkg::CONT_BIT) != 8'h00);
    end

    assign full         = (r_cnt == CW'(FRONT_DEPTH));
    assign o_item_valid = (r_cnt != '0);
    assign o_item       = r_mem[r_rd_ptr];
    assign wr_en        = push & ~full;
    assign rd_en        = i_item_take & o_item_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == PW'(FRONT_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == PW'(FRONT_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_cnt = r_cnt + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= in_item;
        end
    end

endmodule

// ----- design/vlpd_back.sv -----
module vlpd_back #(
    parameter int OUT_DEPTH = vlpd_pkg::DEF_OUT_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_mode,
    input  logic              i_item_valid,
    input  vlpd_pkg::t_item   i_item,
    output logic              o_item_take,
    output logic              empty,
    output vlpd_pkg::t_result o_result,
    input  logic              pop
);

    localparam int PW = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
    localparam int CW = $clog2(OUT_DEPTH + 1);

    // decoder state
    logic [63:0] r_acc, n_acc;
    logic [3:0]  r_vcnt, n_vcnt;
    logic        r_in_pay, n_in_pay;
    logic [63:0] r_rem, n_rem;

    // result queue
    vlpd_pkg::t_result r_mem [OUT_DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          wr_en, rd_en;

    logic              emit;
    vlpd_pkg::t_result res;
    logic [3:0]        limit;
    logic [5:0]        sh_amt;
    logic [63:0]       acc_new;
    logic [63:0]       value;
    logic              last_pay;

    assign o_item_take = i_item_valid & (r_cnt != CW'(OUT_DEPTH));
    assign empty       = (r_cnt == '0);
    assign o_result    = r_mem[r_rd_ptr];
    assign wr_en       = o_item_take & emit;
    assign rd_en       = pop & ~empty;

    assign limit    = (i_mode == vlpd_pkg::MODE_VARINT32) ? vlpd_pkg::LIMIT_32
                                                          : vlpd_pkg::LIMIT_64;
    assign sh_amt   = {2'b00, r_vcnt} * vlpd_pkg::GROUP_BITS;
    assign acc_new  = r_acc | ({56'd0, i_item.data_byte & vlpd_pkg::GROUP_MASK} << sh_amt);
    assign value    = (i_mode == vlpd_pkg::MODE_VARINT32) ? {32'd0, acc_new[31:0]} : acc_new;
    assign last_pay = (r_rem == 64'd1);

    // one decode step per beat
    always_comb begin
        n_acc    = r_acc;
        n_vcnt   = r_vcnt;
        n_in_pay = r_in_pay;
        n_rem    = r_rem;
        emit     = 1'b0;
        res      = '0;
        res.kind = vlpd_pkg::KIND_VALUE;
        res.err  = vlpd_pkg::ERR_NONE;

        if (!i_item.present) begin
            if (i_item.end_flag) begin
                if (r_in_pay) begin
                    emit     = 1'b1;
                    res.kind = vlpd_pkg::KIND_ERROR;
                    res.err  = vlpd_pkg::ERR_SHORT;
                end else if (r_vcnt != 4'd0) begin
                    emit     = 1'b1;
                    res.kind = vlpd_pkg::KIND_ERROR;
                    res.err  = vlpd_pkg::ERR_TRUNCATED;
                end
                n_acc    = '0;
                n_vcnt   = '0;
                n_in_pay = 1'b0;
                n_rem    = '0;
            end
        end else if (r_in_pay) begin
            emit = 1'b1;
            if (i_item.end_flag && !last_pay) begin
                res.kind = vlpd_pkg::KIND_ERROR;
                res.err  = vlpd_pkg::ERR_SHORT;
                n_acc    = '0;
                n_vcnt   = '0;
                n_in_pay = 1'b0;
                n_rem    = '0;
            end else begin
                res.kind  = vlpd_pkg::KIND_PAYLOAD;
                res.pbyte = i_item.data_byte;
                res.last  = last_pay;
                n_rem     = r_rem - 64'd1;
                if (last_pay || i_item.end_flag) begin
                    n_in_pay = 1'b0;
                    n_rem    = '0;
                    n_acc    = '0;
                    n_vcnt   = '0;
                end
            end
        end else if (r_vcnt >= limit) begin
            emit     = 1'b1;
            res.kind = vlpd_pkg::KIND_ERROR;
            res.err  = vlpd_pkg::ERR_OVERLONG;
            n_acc    = '0;
            n_vcnt   = '0;
            n_in_pay = 1'b0;
            n_rem    = '0;
        end else if (i_item.cont) begin
            if (i_item.end_flag) begin
                emit     = 1'b1;
                res.kind = vlpd_pkg::KIND_ERROR;
                res.err  = vlpd_pkg::ERR_TRUNCATED;
                n_acc    = '0;
                n_vcnt   = '0;
                n_in_pay = 1'b0;
                n_rem    = '0;
            end else begin
                n_acc  = acc_new;
                n_vcnt = r_vcnt + 4'd1;
            end
        end else begin
            // varint complete
            emit     = 1'b1;
            n_acc    = '0;
            n_vcnt   = '0;
            res.kind = vlpd_pkg::KIND_VALUE;
            res.value = value;
            res.used  = r_vcnt + 4'd1;
            if (i_mode == vlpd_pkg::MODE_RECORD) begin
                if (value == 64'd0) begin
                    res.last = 1'b1;
                end else if (i_item.end_flag) begin
                    res       = '0;
                    res.kind  = vlpd_pkg::KIND_ERROR;
                    res.err   = vlpd_pkg::ERR_SHORT;
                end else begin
                    n_in_pay = 1'b1;
                    n_rem    = value;
                end
            end
        end
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == PW'(OUT_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == PW'(OUT_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_cnt = r_cnt + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_vcnt   <= '0;
            r_in_pay <= 1'b0;
            r_rem    <= '0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (o_item_take) begin
                r_acc    <= n_acc;
                r_vcnt   <= n_vcnt;
                r_in_pay <= n_in_pay;
                r_rem    <= n_rem;
            end
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= res;
        end
    end

endmodule

// ----- design/varint_length_prefix_decoder.sv -----
// Path: each byte is written into the front queue; the decode step reads it from
//   the queue head and, when it yields a result, writes that result into the result
//   queue, whose head drives the result ports.
// Throughput: one byte per cycle while the result queue has a free slot, set by the decode step in the back end.
// Reset: synchronous, active low; clears both queues, the decoder state and
//   decode_mode (back to varint32).
module varint_length_prefix_decoder #(
    parameter int FRONT_DEPTH = vlpd_pkg::DEF_FRONT_DEPTH,
    parameter int OUT_DEPTH   = vlpd_pkg::DEF_OUT_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write channel: decode_mode
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_data,
    // byte input, queue style
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_input_end,
    // result output, queue style
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_result_kind,
    output logic [63:0] o_decoded_value,
    output logic [7:0]  o_payload_byte,
    output logic [1:0]  o_error_code,
    output logic        o_record_last,
    output logic [3:0]  o_bytes_used
);

    // mode register, always ready; the host must write it only while the block is idle, not enforced by the block
    logic [1:0] r_mode;

    logic              item_valid;
    logic              item_take;
    vlpd_pkg::t_item   item;
    vlpd_pkg::t_result result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= vlpd_pkg::MODE_VARINT32;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mode <= i_cfg_data;
        end
    end

    // front: take byte beats, tag continuation bit, buffer
    vlpd_front #(
        .FRONT_DEPTH (FRONT_DEPTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_data_byte    (i_data_byte),
        .i_byte_present (i_byte_present),
        .i_input_end    (i_input_end),
        .o_item_valid   (item_valid),
        .o_item         (item),
        .i_item_take    (item_take)
    );

    // back: varint accumulate, record payload tracking, result queue.
    // It only pulls a beat when the result queue has a free slot, so a
    // stalled consumer backs up into the front queue and then into full.
    vlpd_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mode       (r_mode),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_item_take  (item_take),
        .empty        (empty),
        .o_result     (result),
        .pop          (pop)
    );

    assign o_result_kind   = result.kind;
    assign o_decoded_value = result.value;
    assign o_payload_byte  = result.pbyte;
    assign o_error_code    = result.err;
    assign o_record_last   = result.last;
    assign o_bytes_used    = result.used;

endmodule
